// ----- sv/lazy_range_add_range_sum_tree_macros.svh -----
// ----------------------------------------------------------------------------
// Range add / range sum block assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LAZY_RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH
`define LAZY_RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LRST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LRST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lrst_pkg.sv -----
// ----------------------------------------------------------------------------
// Range add / range sum package
// Shared constants, datapath operation codes and control structures.
// ----------------------------------------------------------------------------
package lrst_pkg;

  localparam int POSITIONS_DEF = 1024;
  localparam int POS_IN_W      = 11;
  localparam int DELTA_W       = 32;
  localparam int TOTAL_W       = 64;

  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_CLR  = 4'd2;
  localparam logic [3:0] OP_ASET = 4'd3;
  localparam logic [3:0] OP_ARD  = 4'd4;
  localparam logic [3:0] OP_AWR  = 4'd5;
  localparam logic [3:0] OP_QSET = 4'd6;
  localparam logic [3:0] OP_QRD  = 4'd7;
  localparam logic [3:0] OP_QACC = 4'd8;
  localparam logic [3:0] OP_MUL  = 4'd9;
  localparam logic [3:0] OP_ACC  = 4'd10;
  localparam logic [3:0] OP_ZERO = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic       phase;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic add_live;
    logic qry_live;
    logic kind;
    logic nonempty;
    logic hi_inside;
  } dp_stat_t;

endpackage

// ----- sv/lrst_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lrst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/lrst_datapath.sv -----
// ----------------------------------------------------------------------------
// Range add / range sum datapath
// Two Fenwick trees in one RAM (difference and position-weighted difference),
// index walker, multipliers and the result accumulator.
// ----------------------------------------------------------------------------
module lrst_datapath #(
  parameter int POSITIONS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lrst_pkg::dp_cmd_t                     cmd,
  output lrst_pkg::dp_stat_t                    stat,
  input  logic                                  kind,
  input  logic [lrst_pkg::POS_IN_W-1:0]         lo,
  input  logic [lrst_pkg::POS_IN_W-1:0]         hi,
  input  logic signed [lrst_pkg::DELTA_W-1:0]   delta,
  output logic signed [lrst_pkg::TOTAL_W-1:0]   range_total
);
  import lrst_pkg::*;

  localparam int PW = $clog2(POSITIONS + 1);
  localparam int IW = PW + 1;
  localparam int CW = (PW > POS_IN_W) ? PW : POS_IN_W;
  localparam int MW = DELTA_W + PW + 1;
  localparam logic [CW-1:0] POS_C = CW'(POSITIONS);

  logic              kind_r;
  logic [PW-1:0]     lo_r;
  logic [PW-1:0]     hi_r;
  logic signed [DELTA_W-1:0] d_r;
  logic [IW-1:0]     idx;
  logic [63:0]       dv;
  logic [63:0]       dpp;
  logic [PW-1:0]     x;
  logic [63:0]       s1;
  logic [63:0]       s2;
  logic [31+PW:0]    pl;
  logic [31:0]       ph;
  logic [63:0]       acc;

  logic [CW-1:0]     lo_w;
  logic [CW-1:0]     hi_w;
  logic [PW-1:0]     p_sel;
  logic signed [MW-1:0] mprod;
  logic [63:0]       d_ext;
  logic [63:0]       m_ext;
  logic [IW-1:0]     low_bit;
  logic [63:0]       term;
  logic              we;
  logic [PW-1:0]     waddr;
  logic [127:0]      wdata;
  logic [PW-1:0]     raddr;
  logic [127:0]      rdata;

  assign lo_w    = CW'(lo);
  assign hi_w    = CW'(hi);
  assign p_sel   = cmd.phase ? hi_r : lo_r;
  assign mprod   = $signed(d_r) * $signed({1'b0, p_sel});
  assign d_ext   = 64'(d_r);
  assign m_ext   = 64'(mprod);
  assign low_bit = idx & (~idx + IW'(1));
  assign term    = 64'(pl) + {ph, 32'b0} - s2;

  assign we    = (cmd.op == OP_CLR) || (cmd.op == OP_AWR);
  assign waddr = idx[PW-1:0];
  assign wdata = (cmd.op == OP_CLR) ? 128'b0 :
                 {rdata[127:64] + dv, rdata[63:0] + dpp};
  assign raddr = idx[PW-1:0];

  lrst_ram #(
    .WIDTH(128),
    .DEPTH(POSITIONS + 1)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          kind_r <= kind;
          lo_r   <= (lo_w > POS_C) ? PW'(POSITIONS) : lo_w[PW-1:0];
          hi_r   <= (hi_w > POS_C) ? PW'(POSITIONS) : hi_w[PW-1:0];
          d_r    <= delta;
        end
        OP_CLR: begin
          idx <= idx + IW'(1);
        end
        OP_ASET: begin
          idx <= IW'(p_sel) + IW'(1);
          dv  <= cmd.phase ? -d_ext : d_ext;
          dpp <= cmd.phase ? -m_ext : m_ext;
        end
        OP_AWR: begin
          idx <= idx + low_bit;
        end
        OP_QSET: begin
          x   <= cmd.phase ? lo_r : hi_r;
          idx <= IW'(cmd.phase ? lo_r : hi_r);
          s1  <= '0;
          s2  <= '0;
        end
        OP_QACC: begin
          s1  <= s1 + rdata[127:64];
          s2  <= s2 + rdata[63:0];
          idx <= idx - low_bit;
        end
        OP_MUL: begin
          pl <= s1[31:0] * x;
          ph <= 32'(s1[63:32] * x);
        end
        OP_ACC: begin
          acc <= cmd.phase ? acc - term : term;
        end
        OP_ZERO: begin
          acc <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.clr_last  = (idx == IW'(POSITIONS));
  assign stat.add_live  = (idx <= IW'(POSITIONS));
  assign stat.qry_live  = (idx != '0);
  assign stat.kind      = kind_r;
  assign stat.nonempty  = (lo_r < hi_r);
  assign stat.hi_inside = (hi_r < PW'(POSITIONS));
  assign range_total    = acc;

endmodule

// ----- sv/lrst_ctrl.sv -----
// ----------------------------------------------------------------------------
// Range add / range sum controller
// Sequences the clearing pass, the Fenwick update walks and the prefix walks.
// ----------------------------------------------------------------------------
`include "lazy_range_add_range_sum_tree_macros.svh"

module lrst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output lrst_pkg::dp_cmd_t  cmd,
  input  lrst_pkg::dp_stat_t stat
);
  import lrst_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_ASET = 4'd3;
  localparam logic [3:0] S_ARD  = 4'd4;
  localparam logic [3:0] S_AWR  = 4'd5;
  localparam logic [3:0] S_QSET = 4'd6;
  localparam logic [3:0] S_QRD  = 4'd7;
  localparam logic [3:0] S_QACC = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_ACC  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       phase;
  logic       phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd.op     = OP_NONE;
    cmd.phase  = phase;
    unique case (state)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          phase_next = 1'b0;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.kind) begin
          if (stat.nonempty) begin
            state_next = S_QSET;
          end else begin
            cmd.op     = OP_ZERO;
            state_next = S_OUT;
          end
        end else begin
          state_next = stat.nonempty ? S_ASET : S_IDLE;
        end
      end
      S_ASET: begin
        cmd.op     = OP_ASET;
        state_next = S_ARD;
      end
      S_ARD: begin
        if (stat.add_live) begin
          cmd.op     = OP_ARD;
          state_next = S_AWR;
        end else if (!phase && stat.hi_inside) begin
          phase_next = 1'b1;
          state_next = S_ASET;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_AWR: begin
        cmd.op     = OP_AWR;
        state_next = S_ARD;
      end
      S_QSET: begin
        cmd.op     = OP_QSET;
        state_next = S_QRD;
      end
      S_QRD: begin
        if (stat.qry_live) begin
          cmd.op     = OP_QRD;
          state_next = S_QACC;
        end else begin
          state_next = S_MUL;
        end
      end
      S_QACC: begin
        cmd.op     = OP_QACC;
        state_next = S_QRD;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (!phase) begin
          phase_next = 1'b1;
          state_next = S_QSET;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  `LRST_ASSERT_SAME(a_done_busy, done, busy, "result strobe while idle")
  `LRST_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transaction not taken")
  `LRST_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `LRST_ASSERT_SAME(a_clr_quiet, state == S_CLR, !done, "result during clearing pass")

endmodule

// ----- sv/lazy_range_add_range_sum_tree.sv -----
// A query walks the prefix sums at clipped hi and then at clipped lo, then strobes done.
// An add updates at clipped lo and, if hi lies inside the array, at clipped hi, holding busy.
// One transaction at a time; the next one is taken in the first cycle with busy low.
// After rst the block clears its RAM with busy high.
// The result strobe done lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Range add / range sum top level
// Range add and range sum over a fixed array of signed positions.
// ----------------------------------------------------------------------------
module lazy_range_add_range_sum_tree #(
  parameter int POSITIONS = lrst_pkg::POSITIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind,
  input  logic [lrst_pkg::POS_IN_W-1:0]       lo,
  input  logic [lrst_pkg::POS_IN_W-1:0]       hi,
  input  logic signed [lrst_pkg::DELTA_W-1:0] delta,
  output logic                                done,
  output logic signed [lrst_pkg::TOTAL_W-1:0] range_total
);
  import lrst_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lrst_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd),
    .stat (stat)
  );

  lrst_datapath #(
    .POSITIONS(POSITIONS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (kind),
    .lo         (lo),
    .hi         (hi),
    .delta      (delta),
    .range_total(range_total)
  );

endmodule
